// ----- sv/nm182_pkg.sv -----
// Shared types and constants for the mapper 182 bank and IRQ block.
// Used by nm182_mod and nes_mapper182_bank_irq_top; no dependencies.
`default_nettype none

package nm182_pkg;

    localparam int CHR_SLOTS   = 8;
    localparam int BANK_W      = 8;
    localparam int PRG_COUNT_W = 10;
    localparam int CHR_COUNT_W = 12;

    localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RST = 10'd16;
    localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RST = 12'd256;

    localparam logic [15:0] ADDR_MASK   = 16'hF003;
    localparam logic [15:0] ADDR_MIRROR = 16'h8001;
    localparam logic [15:0] ADDR_SELECT = 16'hA000;
    localparam logic [15:0] ADDR_LOAD   = 16'hC000;
    localparam logic [15:0] ADDR_IRQ    = 16'hE003;

    localparam logic [7:0] TARGET_MASK  = 8'h07;
    localparam logic [7:0] PAIR_MASK    = 8'hFE;
    localparam logic [8:0] LAST_VISIBLE = 9'd240;

    typedef enum logic [2:0] {
        TGT_CHR01  = 3'd0,
        TGT_CHR5   = 3'd1,
        TGT_CHR23  = 3'd2,
        TGT_CHR7   = 3'd3,
        TGT_PRG_LO = 3'd4,
        TGT_PRG_HI = 3'd5,
        TGT_CHR4   = 3'd6,
        TGT_CHR6   = 3'd7
    } target_t;

    typedef enum logic {
        CFG_PRG_COUNT = 1'b0,
        CFG_CHR_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [BANK_W-1:0]      dividend;
        logic [CHR_COUNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                   done;
        logic [CHR_COUNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ----- sv/nm182_mod.sv -----
// Serial restoring modulo unit: one dividend bit per cycle over the eight dividend bits.
// Depends on nm182_pkg for the request and response structs.
`default_nettype none

module nm182_mod (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire nm182_pkg::mod_req_t req,
    output nm182_pkg::mod_rsp_t    rsp
);

    localparam int DW = nm182_pkg::BANK_W;
    localparam int RW = nm182_pkg::CHR_COUNT_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [DW-1:0]     dv_reg, dv_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [RW-1:0]     div_reg, div_next;
    logic [RW:0]       shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign shifted = {rem_reg, dv_reg[DW-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dv_next   = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = RW'(shifted - {1'b0, div_reg});
            end else begin
                rem_next = shifted[RW-1:0];
            end
            dv_next  = {dv_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ----- sv/nes_mapper182_bank_irq_top.sv -----
// Mapper 182 bank switching and scanline IRQ counter, top level.
// A load of a bank target with a nonzero bank count passes through ST_DIV and waits there for
// the serial eight-step modulo unit nm182_mod; every other request goes from ST_IDLE to ST_DONE.
// One request is worked at a time; a finished result waits in the output register, and the
// next request is taken in the cycle after a result is registered.
// Synchronous active-low reset restores bank counts 16 and 256, identity CHR slots,
// PRG banks 0 and 1, horizontal mirroring and a disarmed IRQ counter.
`default_nettype none

module nes_mapper182_bank_irq_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // addr[15:0], data[23:16], scanline[32:24], rendering_on[33], zero fill[39:34]
    input  wire logic [39:0] s_tdata,
    // func[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // irq_pulse[0], mirror_vertical[1], prg_bank_lo[9:2], prg_bank_hi[17:10],
    // chr_slot0[25:18] .. chr_slot7[81:74] in steps of 8, zero fill[87:82]
    output logic [87:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_wdata
);

    localparam int BW = nm182_pkg::BANK_W;
    localparam int CW = nm182_pkg::CHR_COUNT_W;
    localparam int PW = nm182_pkg::PRG_COUNT_W;

    nm182_pkg::state_t  state_reg, state_next;
    nm182_pkg::target_t sel_reg, sel_next;
    logic               armed_reg, armed_next;
    logic [BW-1:0]      counter_reg, counter_next;
    logic               mirror_reg, mirror_next;
    logic               pulse_reg, pulse_next;
    logic [BW-1:0]      prg_reg [2];
    logic [BW-1:0]      prg_next [2];
    logic [BW-1:0]      chr_reg [nm182_pkg::CHR_SLOTS];
    logic [BW-1:0]      chr_next [nm182_pkg::CHR_SLOTS];
    logic [PW-1:0]      prg_count_reg;
    logic [CW-1:0]      chr_count_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [87:0]        m_tdata_reg, m_tdata_next;

    nm182_pkg::mod_req_t mod_req;
    nm182_pkg::mod_rsp_t mod_rsp;

    logic          accept;
    logic [15:0]   in_addr;
    logic [7:0]    in_data;
    logic [8:0]    in_line;
    logic          in_rend;
    logic          is_prg;
    logic          is_pair;
    logic          count_ok;
    logic [BW-1:0] dec;
    logic [CW-1:0] rem_inc;
    logic [BW-1:0] rem_lo;
    logic [BW-1:0] rem_hi;

    assign in_addr = s_tdata[15:0];
    assign in_data = s_tdata[23:16];
    assign in_line = s_tdata[32:24];
    assign in_rend = s_tdata[33];

    assign s_tready = (state_reg == nm182_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign is_prg   = (sel_reg == nm182_pkg::TGT_PRG_LO) || (sel_reg == nm182_pkg::TGT_PRG_HI);
    assign is_pair  = (sel_reg == nm182_pkg::TGT_CHR01) || (sel_reg == nm182_pkg::TGT_CHR23);
    assign count_ok = is_prg ? (prg_count_reg != '0) : (chr_count_reg != '0);
    assign dec      = counter_reg - 8'd1;

    // The odd bank of a pair follows from the even remainder by one increment and wrap.
    assign rem_inc = mod_rsp.remainder + 12'd1;
    assign rem_lo  = mod_rsp.remainder[BW-1:0];
    assign rem_hi  = (rem_inc == chr_count_reg) ? '0 : rem_inc[BW-1:0];

    nm182_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nm182_pkg::ST_IDLE;
            sel_reg       <= nm182_pkg::TGT_CHR01;
            armed_reg     <= 1'b0;
            counter_reg   <= '0;
            mirror_reg    <= 1'b0;
            pulse_reg     <= 1'b0;
            prg_reg[0]    <= 8'd0;
            prg_reg[1]    <= 8'd1;
            for (int i = 0; i < nm182_pkg::CHR_SLOTS; i++) begin
                chr_reg[i] <= BW'(i);
            end
            prg_count_reg <= nm182_pkg::PRG_COUNT_RST;
            chr_count_reg <= nm182_pkg::CHR_COUNT_RST;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            armed_reg    <= armed_next;
            counter_reg  <= counter_next;
            mirror_reg   <= mirror_next;
            pulse_reg    <= pulse_next;
            prg_reg      <= prg_next;
            chr_reg      <= chr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (nm182_pkg::cfg_index_t'(cfg_index))
                    nm182_pkg::CFG_PRG_COUNT: prg_count_reg <= cfg_wdata[PW-1:0];
                    nm182_pkg::CFG_CHR_COUNT: chr_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next       = state_reg;
        sel_next         = sel_reg;
        armed_next       = armed_reg;
        counter_next     = counter_reg;
        mirror_next      = mirror_reg;
        pulse_next       = pulse_reg;
        prg_next         = prg_reg;
        chr_next         = chr_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = is_pair ? (in_data & nm182_pkg::PAIR_MASK) : in_data;
        mod_req.divisor  = is_prg ? CW'(prg_count_reg) : chr_count_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            nm182_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = nm182_pkg::ST_DONE;
                    pulse_next = 1'b0;
                    if (!s_tuser) begin
                        unique case (in_addr & nm182_pkg::ADDR_MASK)
                            nm182_pkg::ADDR_MIRROR: mirror_next = ~in_data[0];
                            nm182_pkg::ADDR_SELECT: begin
                                sel_next = nm182_pkg::target_t'(
                                    3'(in_data & nm182_pkg::TARGET_MASK));
                            end
                            nm182_pkg::ADDR_LOAD: begin
                                if (count_ok) begin
                                    mod_req.start = 1'b1;
                                    state_next    = nm182_pkg::ST_DIV;
                                end
                            end
                            nm182_pkg::ADDR_IRQ: begin
                                counter_next = in_data;
                                armed_next   = (in_data != 8'd0);
                            end
                            default: ;
                        endcase
                    end else if (armed_reg && (in_line <= nm182_pkg::LAST_VISIBLE) && in_rend) begin
                        counter_next = dec;
                        if (dec == 8'd0) begin
                            armed_next = 1'b0;
                            pulse_next = 1'b1;
                        end
                    end
                end
            end
            nm182_pkg::ST_DIV: begin
                if (mod_rsp.done) begin
                    state_next = nm182_pkg::ST_DONE;
                    unique case (sel_reg)
                        nm182_pkg::TGT_CHR01: begin
                            chr_next[0] = rem_lo;
                            chr_next[1] = rem_hi;
                        end
                        nm182_pkg::TGT_CHR5:   chr_next[5] = rem_lo;
                        nm182_pkg::TGT_CHR23: begin
                            chr_next[2] = rem_lo;
                            chr_next[3] = rem_hi;
                        end
                        nm182_pkg::TGT_CHR7:   chr_next[7] = rem_lo;
                        nm182_pkg::TGT_PRG_LO: prg_next[0] = rem_lo;
                        nm182_pkg::TGT_PRG_HI: prg_next[1] = rem_lo;
                        nm182_pkg::TGT_CHR4:   chr_next[4] = rem_lo;
                        nm182_pkg::TGT_CHR6:   chr_next[6] = rem_lo;
                        default: ;
                    endcase
                end
            end
            nm182_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0,
                                     chr_reg[7], chr_reg[6], chr_reg[5], chr_reg[4],
                                     chr_reg[3], chr_reg[2], chr_reg[1], chr_reg[0],
                                     prg_reg[1], prg_reg[0], mirror_reg, pulse_reg};
                    state_next    = nm182_pkg::ST_IDLE;
                end
            end
            default: state_next = nm182_pkg::ST_IDLE;
        endcase
    end

    // A pulse is only reported by the tick that also disarmed the counter.
    assert property (@(posedge aclk) disable iff (!aresetn) pulse_reg |-> !armed_reg)
        else $error("IRQ pulse pending while the counter is still armed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_rsp.done |-> (state_reg == nm182_pkg::ST_DIV))
        else $error("Modulo unit finished outside a bank load");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == nm182_pkg::ST_DONE))
        else $error("Result appeared without a finished request");

endmodule

`default_nettype wire
